// File: rtl/plil_pkg.sv
// Shared types and constants for the positional list block.
// Used by the list top level and its checker; depends on nothing else.
package plil_pkg;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
  localparam int unsigned POS_W      = 7;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 40;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_DUMP   = 2'd2
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_BADPOS = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_EMPTY  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_STEP,
    ST_INS_WR,
    ST_DEL_STEP,
    ST_DEL_WR,
    ST_DUMP_RD,
    ST_DUMP_EMIT,
    ST_RESULT
  } state_e;

endpackage

// File: rtl/positional_list_insert_delete_top.sv
// Top level of the positional list: sequencer, length count and output register.
// Depends on plil_pkg and plil_ram.
//
// The block keeps an ordered list of up to 64 signed words in one RAM with a
// length count, and the list is empty after reset. Each input word carries a
// mode in tuser: insert before a 1-based position, delete at a 1-based
// position, or dump the whole list; mode 3 is dropped without a result. One
// word is worked on at a time and tready stays low until the sequencer is
// back in idle. Every RAM move goes through the single read port and the
// single write port, with a read state and then a write state per moved
// entry; a dump reads each entry and then emits it. A refused insert or
// delete, or a dump of an empty list, goes straight to the result state.
// A stalled m_axis holds back each dump word and the final result of the
// other modes. Results sit in an output register, so a new input word can
// be taken while the last result still waits on m_axis. An insert is checked
// for a bad position before it is checked for a full list. Reported count is
// the list length after the operation.
module positional_list_insert_delete_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata fields from bit 0 up: position[6:0], value[38:7], zero padding.
  input  logic [plil_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // tuser fields from bit 0 up: mode[1:0].
  input  logic [plil_pkg::MODE_W-1:0]        s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata fields from bit 0 up: item[31:0], count[38:32], zero padding.
  output logic [plil_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // tuser fields from bit 0 up: status[1:0].
  output logic [plil_pkg::STAT_W-1:0]        m_axis_tuser,
  output logic                               m_axis_tlast
);

  localparam int unsigned AW = plil_pkg::ADDR_W;
  localparam int unsigned CW = plil_pkg::CNT_W;
  localparam int unsigned PW = plil_pkg::POS_W;
  localparam int unsigned WW = plil_pkg::WORD_W;

  plil_pkg::state_e state_q, state_d;
  logic [AW-1:0]    ptr_q, ptr_d;
  logic [CW-1:0]    len_q, len_d;
  logic [PW-1:0]    pos_q, pos_d;
  logic [WW-1:0]    value_q, value_d;
  plil_pkg::status_e status_q, status_d;

  // Output register.
  logic                           m_valid_q;
  logic [WW-1:0]                  m_item_q;
  logic [PW-1:0]                  m_count_q;
  plil_pkg::status_e              m_status_q;
  logic                           m_last_q;

  logic                           out_free;
  logic                           out_load;
  logic [WW-1:0]                  out_item;
  plil_pkg::status_e              out_status;
  logic                           out_last;

  // RAM port signals.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [WW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [WW-1:0] ram_rdata;

  logic [PW-1:0] in_pos;
  logic [WW-1:0] in_value;
  logic [PW-1:0] len_ext;
  logic [PW-1:0] pos_m1;
  logic          in_accept;

  assign in_pos    = s_axis_tdata[PW-1:0];
  assign in_value  = s_axis_tdata[PW+WW-1:PW];
  assign len_ext   = PW'(len_q);
  assign pos_m1    = pos_q - PW'(1);
  assign out_free  = !m_valid_q || m_axis_tready;

  assign s_axis_tready = (state_q == plil_pkg::ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  plil_ram #(
    .WIDTH (WW),
    .DEPTH (plil_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= plil_pkg::ST_IDLE;
      len_q   <= '0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q    <= ptr_d;
    pos_q    <= pos_d;
    value_q  <= value_d;
    status_q <= status_d;
  end

  always_comb begin
    state_d    = state_q;
    ptr_d      = ptr_q;
    len_d      = len_q;
    pos_d      = pos_q;
    value_d    = value_q;
    status_d   = status_q;
    ram_we     = 1'b0;
    ram_waddr  = ptr_q;
    ram_wdata  = ram_rdata;
    ram_re     = 1'b0;
    ram_raddr  = ptr_q;
    out_load   = 1'b0;
    out_item   = '0;
    out_status = status_q;
    out_last   = 1'b1;

    case (state_q)
      plil_pkg::ST_IDLE: begin
        if (in_accept) begin
          pos_d   = in_pos;
          value_d = in_value;
          case (plil_pkg::mode_e'(s_axis_tuser))
            plil_pkg::MODE_INSERT: begin
              if (in_pos == '0 || in_pos > len_ext + PW'(1)) begin
                status_d = plil_pkg::STAT_BADPOS;
                state_d  = plil_pkg::ST_RESULT;
              end else if (len_q == CW'(plil_pkg::DEPTH)) begin
                status_d = plil_pkg::STAT_FULL;
                state_d  = plil_pkg::ST_RESULT;
              end else begin
                status_d = plil_pkg::STAT_OK;
                ptr_d    = len_q[AW-1:0];
                state_d  = plil_pkg::ST_INS_STEP;
              end
            end
            plil_pkg::MODE_DELETE: begin
              if (in_pos == '0 || in_pos > len_ext) begin
                status_d = plil_pkg::STAT_BADPOS;
                state_d  = plil_pkg::ST_RESULT;
              end else begin
                status_d = plil_pkg::STAT_OK;
                ptr_d    = AW'(in_pos - PW'(1));
                state_d  = plil_pkg::ST_DEL_STEP;
              end
            end
            plil_pkg::MODE_DUMP: begin
              if (len_q == '0) begin
                status_d = plil_pkg::STAT_EMPTY;
                state_d  = plil_pkg::ST_RESULT;
              end else begin
                status_d = plil_pkg::STAT_OK;
                ptr_d    = '0;
                state_d  = plil_pkg::ST_DUMP_RD;
              end
            end
            default: begin
              state_d = plil_pkg::ST_IDLE;
            end
          endcase
        end
      end

      // Walk down from the tail, moving each entry one place up.
      plil_pkg::ST_INS_STEP: begin
        if (PW'(ptr_q) >= pos_q) begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q - AW'(1);
          state_d   = plil_pkg::ST_INS_WR;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = pos_m1[AW-1:0];
          ram_wdata = value_q;
          len_d     = len_q + CW'(1);
          state_d   = plil_pkg::ST_RESULT;
        end
      end

      plil_pkg::ST_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q;
        ptr_d     = ptr_q - AW'(1);
        state_d   = plil_pkg::ST_INS_STEP;
      end

      // Walk up from the hole, moving each entry one place down.
      plil_pkg::ST_DEL_STEP: begin
        if (CW'(ptr_q) + CW'(1) < len_q) begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q + AW'(1);
          state_d   = plil_pkg::ST_DEL_WR;
        end else begin
          len_d   = len_q - CW'(1);
          state_d = plil_pkg::ST_RESULT;
        end
      end

      plil_pkg::ST_DEL_WR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q;
        ptr_d     = ptr_q + AW'(1);
        state_d   = plil_pkg::ST_DEL_STEP;
      end

      plil_pkg::ST_DUMP_RD: begin
        ram_re  = 1'b1;
        state_d = plil_pkg::ST_DUMP_EMIT;
      end

      // The RAM read register holds its word until the next read, so a
      // stalled output simply waits here.
      plil_pkg::ST_DUMP_EMIT: begin
        out_item   = ram_rdata;
        out_status = plil_pkg::STAT_OK;
        out_last   = (CW'(ptr_q) + CW'(1) == len_q);
        if (out_free) begin
          out_load = 1'b1;
          if (out_last) begin
            state_d = plil_pkg::ST_IDLE;
          end else begin
            ptr_d   = ptr_q + AW'(1);
            state_d = plil_pkg::ST_DUMP_RD;
          end
        end
      end

      plil_pkg::ST_RESULT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = plil_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = plil_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_item_q   <= out_item;
      m_status_q <= out_status;
      m_last_q   <= out_last;
      m_count_q  <= PW'(len_q);
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(plil_pkg::OUT_DATA_W - WW - PW){1'b0}}, m_count_q, m_item_q};
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tlast  = m_last_q;

endmodule

// File: rtl/plil_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Holds the list entries; depends on nothing else.
module plil_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/plil_checker.sv
// Port-level assertions for the positional list top level, with its bind.
// Depends on plil_pkg.
module plil_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [plil_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input logic [plil_pkg::MODE_W-1:0]      s_axis_tuser,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [plil_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input logic [plil_pkg::STAT_W-1:0]      m_axis_tuser,
  input logic                             m_axis_tlast
);

  logic [plil_pkg::POS_W-1:0]  out_count;
  logic [plil_pkg::WORD_W-1:0] out_item;
  logic                        in_busy_mode;

  assign out_item     = m_axis_tdata[plil_pkg::WORD_W-1:0];
  assign out_count    = m_axis_tdata[plil_pkg::WORD_W+plil_pkg::POS_W-1:plil_pkg::WORD_W];
  assign in_busy_mode = s_axis_tuser inside {plil_pkg::MODE_INSERT, plil_pkg::MODE_DELETE,
                                             plil_pkg::MODE_DUMP};

  // A word that starts real work keeps the input closed on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && in_busy_mode |=> !s_axis_tready)
    else $error("input accepted again right after a working word");

  // The empty-list reply is a single final word with zero item and count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == plil_pkg::STAT_EMPTY |->
      m_axis_tlast && out_item == '0 && out_count == '0)
    else $error("malformed empty-list reply");

  // Refused operations give one final word with a zero item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == plil_pkg::STAT_BADPOS ||
                      m_axis_tuser == plil_pkg::STAT_FULL) |->
      m_axis_tlast && out_item == '0)
    else $error("malformed refusal reply");

  // The reported length never exceeds the store depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> out_count <= plil_pkg::POS_W'(plil_pkg::DEPTH))
    else $error("reported count beyond depth");

  // A stalled output word holds still.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled output word changed");

endmodule

bind positional_list_insert_delete_top plil_checker u_plil_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// File: tb/sv/testbench.sv
// Self-checking bench for positional_list_insert_delete_top: drives insert, delete
// and dump words, predicts every result word and checks it on the master side.
// Depends on plil_pkg and the list RTL only.
module testbench;
  import plil_pkg::*;

  // Mode 3 has no member in mode_e; the block must drop it silently.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int MAX_REPORTS = 20;
  // The slowest legal run is far below this: a few hundred words, each dump at most
  // 64 results plus random back-pressure, each shift moving at most the whole list.
  localparam int TIMEOUT_CYCLES = 1_000_000;
  // Longest single operation is a dump of a full list or an insert at the head of a nearly full list.
  localparam int SETTLE_CYCLES = 200;
  // Least number of working words in one random phase.
  localparam int PHASE_WORDS = 60;

  typedef struct {
    logic [MODE_W-1:0] op;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] word;
  } list_cmd_t;

  typedef struct {
    status_e           status;
    logic [WORD_W-1:0] item;
    logic              last;
    logic [CNT_W-1:0]  count;
  } list_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // tdata fields from bit 0 up: position[6:0], value[38:7], zero padding.
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  // tuser fields from bit 0 up: mode[1:0].
  logic [MODE_W-1:0]     s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // tdata fields from bit 0 up: item[31:0], count[38:32], zero padding.
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  // tuser fields from bit 0 up: status[1:0].
  logic [STAT_W-1:0]     m_axis_tuser;
  logic                  m_axis_tlast;

  // Words waiting to be offered, and the results the list must still produce.
  list_cmd_t    pending_q[$];
  list_result_t due_results_q[$];

  // Shadow copy of the list that the predictor keeps in step with the block.
  logic [WORD_W-1:0] shadow_words [DEPTH];
  int                shadow_len = 0;

  // Length as the stimulus generator expects it once all queued words are taken.
  int gen_len = 0;

  // Set at the rising edge that accepts a word, cleared when the next one is loaded.
  bit word_taken = 1'b0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  int n_inserts = 0, n_deletes = 0, n_dumps = 0, n_ignored = 0;
  int n_badpos = 0, n_full = 0, n_empty = 0, n_checked = 0, n_errors = 0;

  positional_list_insert_delete_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // A hard stop in case the block hangs or stops producing results.
  initial begin
    #(TIMEOUT_CYCLES * 10);
    $display("TB_ERROR");
    $finish;
  end

  function automatic void queue_result(status_e st, logic [WORD_W-1:0] item, logic last,
                                       int count);
    list_result_t r;
    r.status = st;
    r.item   = item;
    r.last   = last;
    r.count  = CNT_W'(count);
    due_results_q.push_back(r);
    case (st)
      STAT_BADPOS: n_badpos++;
      STAT_FULL:   n_full++;
      STAT_EMPTY:  n_empty++;
      default: ;
    endcase
  endfunction

  // Applies one accepted word to the shadow list and queues the results it causes.
  // Position is checked before fullness, so a bad position on a full list reports
  // a bad position.
  function automatic void apply_list_op(logic [MODE_W-1:0] op, int p, logic [WORD_W-1:0] word);
    status_e st;
    int a;
    case (op)
      MODE_INSERT: begin
        n_inserts++;
        if (p < 1 || p > shadow_len + 1) begin
          st = STAT_BADPOS;
        end else if (shadow_len >= int'(DEPTH)) begin
          st = STAT_FULL;
        end else begin
          for (a = shadow_len; a > p - 1; a--) shadow_words[a] = shadow_words[a - 1];
          shadow_words[p - 1] = word;
          shadow_len++;
          st = STAT_OK;
        end
        queue_result(st, '0, 1'b1, shadow_len);
      end
      MODE_DELETE: begin
        n_deletes++;
        if (p < 1 || p > shadow_len) begin
          st = STAT_BADPOS;
        end else begin
          for (a = p - 1; a + 1 < shadow_len; a++) shadow_words[a] = shadow_words[a + 1];
          shadow_len--;
          st = STAT_OK;
        end
        queue_result(st, '0, 1'b1, shadow_len);
      end
      MODE_DUMP: begin
        n_dumps++;
        if (shadow_len == 0) begin
          queue_result(STAT_EMPTY, '0, 1'b1, 0);
        end else begin
          for (a = 0; a < shadow_len; a++) begin
            queue_result(STAT_OK, shadow_words[a], a == shadow_len - 1, shadow_len);
          end
        end
      end
      default: begin
        n_ignored++;
      end
    endcase
  endfunction

  function automatic void check_field(string what, logic [WORD_W-1:0] want,
                                      logic [WORD_W-1:0] got);
    if (want !== got) begin
      if (n_errors < MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      end
      n_errors++;
    end
  endfunction

  // Monitor and predictor share one process so that a result word and a newly
  // accepted input word at the same edge are handled in a fixed order. A result
  // always leaves after the edge that accepted its input, so checking first is safe.
  always @(posedge clk_i) begin
    list_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_results_q.size() == 0) begin
          if (n_errors < MAX_REPORTS) begin
            $display("%0t: unexpected result word, expected none, actual status %0d item %h",
                     $time, m_axis_tuser, m_axis_tdata[WORD_W-1:0]);
          end
          n_errors++;
        end else begin
          want = due_results_q.pop_front();
          check_field("status", want.status, m_axis_tuser);
          check_field("item", want.item, m_axis_tdata[WORD_W-1:0]);
          check_field("last", want.last, m_axis_tlast);
          check_field("count", want.count, m_axis_tdata[WORD_W +: CNT_W]);
          n_checked++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        apply_list_op(s_axis_tuser, int'(s_axis_tdata[POS_W-1:0]),
                      s_axis_tdata[POS_W +: WORD_W]);
        word_taken = 1'b1;
      end
    end
  end

  // Driver: inputs move only on the falling edge. A word stays on the bus until it
  // is taken; between words the sender may idle, and the receiver stalls at random.
  always @(negedge clk_i) begin
    list_cmd_t cmd;
    if (rst_ni) begin
      if (!s_axis_tvalid || word_taken) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cmd = pending_q.pop_front();
          s_axis_tdata  <= {1'b0, cmd.word, cmd.pos};
          s_axis_tuser  <= cmd.op;
          s_axis_tvalid <= 1'b1;
          word_taken = 1'b0;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Queues one word and tracks the length it will leave behind, so that later
  // positions can be aimed at the valid range.
  function automatic void push_cmd(logic [MODE_W-1:0] op, int p, logic [WORD_W-1:0] word);
    list_cmd_t cmd;
    cmd.op   = op;
    cmd.pos  = POS_W'(p);
    cmd.word = word;
    pending_q.push_back(cmd);
    if (op == MODE_INSERT && p >= 1 && p <= gen_len + 1 && gen_len < int'(DEPTH)) begin
      gen_len++;
    end else if (op == MODE_DELETE && p >= 1 && p <= gen_len) begin
      gen_len--;
    end
  endfunction

  // Favors the head and the tail of the valid range.
  function automatic int pick_pos(int hi);
    int r;
    r = $urandom_range(9);
    if (r < 3) return 1;
    if (r < 6) return hi;
    return int'($urandom_range(hi, 1));
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(19))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Holds the sender back until the list has delivered every predicted result.
  task automatic drain();
    while (pending_q.size() != 0 || (s_axis_tvalid && !word_taken) ||
           due_results_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // One random phase. Most words are well-formed inserts and deletes aimed at the
  // current list; the rest are dumps and noise with any mode and position. A
  // filling phase keeps going until the list is full and then pokes at the limit.
  task automatic run_phase(int idle_pct, int stall_pct, int ins_pct, bit fill_up);
    int n;
    int r;
    logic [MODE_W-1:0] op;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    n = 0;
    while (n < PHASE_WORDS || (fill_up && gen_len < int'(DEPTH))) begin
      r = $urandom_range(99);
      if (r < 10) begin
        op = MODE_W'($urandom_range(3));
        push_cmd(op, $urandom_range(127), $urandom);
        if (op != MODE_UNUSED) n++;
      end else if (r < 16) begin
        push_cmd(MODE_DUMP, $urandom_range(127), $urandom);
        n++;
      end else if (r < 16 + ins_pct) begin
        push_cmd(MODE_INSERT, pick_pos(gen_len + 1), pick_word());
        n++;
      end else begin
        push_cmd(MODE_DELETE, (gen_len == 0) ? 1 : pick_pos(gen_len), $urandom);
        n++;
      end
    end
    if (fill_up) begin
      // A full list refuses a valid position as full, but a bad one as bad.
      push_cmd(MODE_INSERT, gen_len + 1, pick_word());
      push_cmd(MODE_INSERT, 1, pick_word());
      push_cmd(MODE_INSERT, gen_len + 2, pick_word());
      push_cmd(MODE_INSERT, 0, pick_word());
    end
    push_cmd(MODE_DUMP, 0, '0);
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words: refusals on an empty list, inserts at head, tail and middle
    // with extreme values, the unused mode, deletes out of range and at both ends.
    push_cmd(MODE_DUMP, 0, '0);
    push_cmd(MODE_DELETE, 1, 32'hffff_ffff);
    push_cmd(MODE_INSERT, 0, 32'h1234_5678);
    push_cmd(MODE_INSERT, 2, 32'h8765_4321);
    push_cmd(MODE_INSERT, 1, 32'h8000_0000);
    push_cmd(MODE_INSERT, 2, 32'h7fff_ffff);
    push_cmd(MODE_INSERT, 1, 32'hffff_ffff);
    push_cmd(MODE_INSERT, 2, 32'h0000_0000);
    push_cmd(MODE_INSERT, 127, 32'h5555_aaaa);
    push_cmd(MODE_UNUSED, 3, 32'haaaa_5555);
    push_cmd(MODE_DUMP, 127, 32'hffff_ffff);
    push_cmd(MODE_DELETE, 5, '0);
    push_cmd(MODE_DELETE, 0, '0);
    push_cmd(MODE_DELETE, 127, '0);
    push_cmd(MODE_DELETE, 4, '0);
    push_cmd(MODE_DELETE, 1, '0);
    push_cmd(MODE_INSERT, 3, 32'h0000_0001);
    push_cmd(MODE_DUMP, 0, '0);
    drain();

    // Random phases: free flow, slow sender, slow receiver, both slow at times.
    run_phase(0, 0, 80, 1'b1);
    run_phase(78, 0, 20, 1'b0);
    run_phase(0, 78, 80, 1'b1);
    run_phase(22, 22, 42, 1'b0);

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Run covered %0d inserts, %0d deletes, %0d dumps and %0d dropped words;",
             n_inserts, n_deletes, n_dumps, n_ignored);
    $display("%0d results checked, %0d bad-position, %0d full and %0d empty-dump refusals.",
             n_checked, n_badpos, n_full, n_empty);
    if (n_errors == 0 && due_results_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
